### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the IMU frame parser.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while the given reset is asserted.
`define IMUSFP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Same check on the house clock and reset names.
`define IMUSFP_ASSERT_STD(lbl, prop) \
    `IMUSFP_ASSERT(lbl, i_clk, i_rst_n, prop)

`endif

### src/imusfp_pkg.sv
// ----------------------------------------------------------------------------
// IMU serial frame parser package
// Frame constants, record type codes and the frame event type.
// ----------------------------------------------------------------------------
package imusfp_pkg;

    localparam logic [7:0] HDR_BYTE    = 8'h55;
    localparam int         FRAME_LEN   = 11;
    localparam int         PAYLOAD_LEN = 8;
    localparam int         POS_W       = $clog2(FRAME_LEN);
    localparam int         PAY_IDX_W   = $clog2(PAYLOAD_LEN);

    localparam logic [POS_W-1:0] POS_HDR  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_TYPE = POS_W'(1);
    localparam logic [POS_W-1:0] POS_PAY  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_LEN - 1);

    localparam logic [7:0] TYPE_ACCEL = 8'h51;
    localparam logic [7:0] TYPE_RATE  = 8'h52;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;

    typedef logic signed [15:0] t_word;

    typedef struct packed {
        logic             last;
        logic             done;
        logic [7:0]       rtype;
        t_word [2:0]      words;
    } t_frame_evt;

endpackage

### src/imu_serial_frame_parser_core.sv
// ----------------------------------------------------------------------------
// IMU serial frame parser core
// Assembles 11-byte sensor frames from received bytes and reports the latest
// acceleration, angular-rate and angle words on every completed frame.
// ----------------------------------------------------------------------------
// The result appears in the cycle after the eleventh byte of a frame is accepted.
// Throughput: one byte per cycle; only the last byte of a frame waits while
// the previous result is still held in the output register.
// Reset: synchronous, active low; position, triples, ready flag and output
// valid are cleared. No clearing pass is needed.
module imu_serial_frame_parser_core
    import imusfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_frame_type,
    output t_word       o_accel_x,
    output t_word       o_accel_y,
    output t_word       o_accel_z,
    output t_word       o_rate_x,
    output t_word       o_rate_y,
    output t_word       o_rate_z,
    output t_word       o_angle_x,
    output t_word       o_angle_y,
    output t_word       o_angle_z,
    output logic        o_sensor_ready
);

    t_frame_evt  w_evt;
    logic        w_in_acc;
    logic        w_out_acc;

    t_word [2:0] r_accel, n_accel;
    t_word [2:0] r_rate,  n_rate;
    t_word [2:0] r_angle, n_angle;
    logic        r_ready, n_ready;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_type;

    assign o_stall   = r_out_valid && i_stall && w_evt.last;
    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = r_out_valid && !i_stall;

    imusfp_frame u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_in_acc),
        .i_rx_byte (i_rx_byte),
        .o_evt     (w_evt)
    );

    always_comb begin
        n_accel     = r_accel;
        n_rate      = r_rate;
        n_angle     = r_angle;
        n_out_valid = w_out_acc ? 1'b0 : r_out_valid;
        if (w_evt.done) begin
            unique case (w_evt.rtype)
                TYPE_ACCEL: n_accel = w_evt.words;
                TYPE_RATE:  n_rate  = w_evt.words;
                TYPE_ANGLE: n_angle = w_evt.words;
                default:    ;
            endcase
            n_out_valid = 1'b1;
        end
        n_ready = r_ready || (w_evt.done && n_angle[0] != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel     <= '0;
            r_rate      <= '0;
            r_angle     <= '0;
            r_ready     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_accel     <= n_accel;
            r_rate      <= n_rate;
            r_angle     <= n_angle;
            r_ready     <= n_ready;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_evt.done) begin
            r_out_type <= w_evt.rtype;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_frame_type   = r_out_type;
    assign o_accel_x      = r_accel[0];
    assign o_accel_y      = r_accel[1];
    assign o_accel_z      = r_accel[2];
    assign o_rate_x       = r_rate[0];
    assign o_rate_y       = r_rate[1];
    assign o_rate_z       = r_rate[2];
    assign o_angle_x      = r_angle[0];
    assign o_angle_y      = r_angle[1];
    assign o_angle_z      = r_angle[2];
    assign o_sensor_ready = r_ready;

`include "assert_macros.svh"

    `IMUSFP_ASSERT_STD(a_no_overwrite, (w_evt.done && r_out_valid) |-> w_out_acc)
    `IMUSFP_ASSERT_STD(a_ready_sticky, r_ready |=> r_ready)
    `IMUSFP_ASSERT_STD(a_triples_hold, (r_out_valid && !w_out_acc) |=> $stable(r_angle))
    `IMUSFP_ASSERT(a_result_from_frame, i_clk, i_rst_n,
        (!r_out_valid || w_out_acc) ##1 r_out_valid |-> $past(w_evt.done))

endmodule

### src/imusfp_frame.sv
// ----------------------------------------------------------------------------
// IMU frame assembler
// Tracks the byte position, holds the type and payload bytes and flags the
// completion of each frame together with its decoded triple.
// ----------------------------------------------------------------------------
module imusfp_frame
    import imusfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    output t_frame_evt o_evt
);

    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  n_pos;
    logic [7:0]        r_type;
    logic [7:0]        r_pay [PAYLOAD_LEN];
    logic [POS_W-1:0]  w_pay_off;

    assign w_pay_off = r_pos - POS_PAY;

    always_comb begin
        n_pos = r_pos;
        if (i_accept) begin
            priority if (r_pos == POS_HDR) begin
                n_pos = (i_rx_byte == HDR_BYTE) ? POS_TYPE : POS_HDR;
            end else if (r_pos >= POS_LAST) begin
                n_pos = POS_HDR;
            end else begin
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HDR;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && r_pos == POS_TYPE) begin
            r_type <= i_rx_byte;
        end
        if (i_accept && r_pos >= POS_PAY && r_pos < POS_LAST) begin
            r_pay[w_pay_off[PAY_IDX_W-1:0]] <= i_rx_byte;
        end
    end

    always_comb begin
        o_evt.last  = (r_pos == POS_LAST);
        o_evt.done  = i_accept && (r_pos == POS_LAST);
        o_evt.rtype = r_type;
        for (int k = 0; k < 3; k++) begin
            o_evt.words[k] = {r_pay[2*k+1], r_pay[2*k]};
        end
    end

`include "assert_macros.svh"

    `IMUSFP_ASSERT_STD(a_pos_range, r_pos <= POS_LAST)
    `IMUSFP_ASSERT_STD(a_bad_hdr_stays,
        (i_accept && r_pos == POS_HDR && i_rx_byte != HDR_BYTE) |=> r_pos == POS_HDR)
    `IMUSFP_ASSERT_STD(a_type_then_payload,
        (i_accept && r_pos == POS_TYPE) |=> r_pos == POS_PAY)

endmodule
